// ===== design/gdd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdd_pkg: shared types, constants and calendar functions
// Item types for the day difference block, multiplier sizes and month tables.
// ----------------------------------------------------------------------------
package gdd_pkg;

  localparam int unsigned YEAR_MAX_DEF = 9999;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned COUNT_W = 22;
  localparam int unsigned YMAX_W  = 16;

  // shared multiplier and serial day number sizes
  localparam int unsigned MUL_W   = YEAR_W;
  localparam int unsigned PROD_W  = 2 * MUL_W;
  localparam int unsigned SER_W   = 24;

  // divide by 100 as multiply by reciprocal and shift, exact below 2**14
  localparam logic [MUL_W-1:0] RECIP_100 = MUL_W'(5243);
  localparam int unsigned      RECIP_SH  = 19;
  localparam int unsigned      QUOT_W    = PROD_W - RECIP_SH;

  localparam logic [MUL_W-1:0] CENTURY   = MUL_W'(100);
  localparam logic [MUL_W-1:0] YEAR_DAYS = MUL_W'(365);

  localparam logic [0:0] STATUS_OK  = 1'b0;
  localparam logic [0:0] STATUS_BAD = 1'b1;

  typedef struct packed {
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [DAY_W-1:0]   end_day;
    logic [MONTH_W-1:0] end_month;
    logic [YEAR_W-1:0]  end_year;
    logic               count_end_day;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] day_count;
    logic               status;
  } out_item_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    len = DAY_W'(31);
    if (m == MONTH_W'(2)) begin
      len = leap ? DAY_W'(29) : DAY_W'(28);
    end else if (m inside {MONTH_W'(4), MONTH_W'(6), MONTH_W'(9), MONTH_W'(11)}) begin
      len = DAY_W'(30);
    end
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    case (m)
      MONTH_W'(1):  n = 9'd0;
      MONTH_W'(2):  n = 9'd31;
      MONTH_W'(3):  n = 9'd59;
      MONTH_W'(4):  n = 9'd90;
      MONTH_W'(5):  n = 9'd120;
      MONTH_W'(6):  n = 9'd151;
      MONTH_W'(7):  n = 9'd181;
      MONTH_W'(8):  n = 9'd212;
      MONTH_W'(9):  n = 9'd243;
      MONTH_W'(10): n = 9'd273;
      MONTH_W'(11): n = 9'd304;
      MONTH_W'(12): n = 9'd334;
      default:      n = 9'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== design/gdd_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdd_mul: shared registered multiplier
// One unsigned multiply per cycle, product available the cycle after.
// ----------------------------------------------------------------------------
module gdd_mul (
  input  wire logic                        clk,
  input  wire logic [gdd_pkg::MUL_W-1:0]   mul_a,
  input  wire logic [gdd_pkg::MUL_W-1:0]   mul_b,
  output logic      [gdd_pkg::PROD_W-1:0]  prod_r
);

  logic [gdd_pkg::PROD_W-1:0] prod_nxt;

  assign prod_nxt = gdd_pkg::PROD_W'(mul_a) * gdd_pkg::PROD_W'(mul_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule
`default_nettype wire

// ===== design/gregorian_day_difference.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_day_difference: days between two Gregorian dates
// Result: registered once both dates have passed their steps and the result
// stage, later while the previous result still waits for out_ready.
// Items: a new item is taken only in idle, after the last result is loaded; each
// date takes six steps, four of them through the one shared multiplier (year / 100,
// (year / 100) * 100, (year-1) / 100, (year-1) * 365).
// Reset: synchronous active low, returns to idle and drops out_valid.
// ----------------------------------------------------------------------------
module gregorian_day_difference #(
  parameter int unsigned YEAR_MAX = gdd_pkg::YEAR_MAX_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire gdd_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output gdd_pkg::out_item_t      out_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_YQ   = 3'd1;
  localparam logic [2:0] ST_YR   = 3'd2;
  localparam logic [2:0] ST_PQ   = 3'd3;
  localparam logic [2:0] ST_PM   = 3'd4;
  localparam logic [2:0] ST_ACC  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  localparam int unsigned SER_W  = gdd_pkg::SER_W;
  localparam int unsigned MUL_W  = gdd_pkg::MUL_W;
  localparam int unsigned QUOT_W = gdd_pkg::QUOT_W;

  logic [2:0]                  state_r, state_nxt;
  logic                        sel_r, sel_nxt;
  gdd_pkg::in_item_t           in_r, in_nxt;
  logic [QUOT_W-1:0]           qy_r, qy_nxt;
  logic [QUOT_W-1:0]           qp_r, qp_nxt;
  logic                        leap_r, leap_nxt;
  logic [SER_W-1:0]            acc_r, acc_nxt;
  logic [SER_W-1:0]            ser_a_r, ser_a_nxt;
  logic [SER_W-1:0]            ser_b_r, ser_b_nxt;
  logic                        bad_r, bad_nxt;
  gdd_pkg::out_item_t          out_r, out_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic [MUL_W-1:0]            mul_a, mul_b;
  logic [gdd_pkg::PROD_W-1:0]  prod_r;
  logic [QUOT_W-1:0]           quot;

  logic [gdd_pkg::DAY_W-1:0]   cur_d;
  logic [gdd_pkg::MONTH_W-1:0] cur_m;
  logic [gdd_pkg::YEAR_W-1:0]  cur_y;
  logic [gdd_pkg::YEAR_W-1:0]  cur_p;
  logic                        cent;
  logic                        date_ok;
  logic                        leap_add;
  logic [SER_W-1:0]            serial;
  logic [SER_W-1:0]            diff;
  logic [SER_W-1:0]            cnt;
  logic                        out_free;

  gdd_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  assign cur_d = sel_r ? in_r.end_day   : in_r.start_day;
  assign cur_m = sel_r ? in_r.end_month : in_r.start_month;
  assign cur_y = sel_r ? in_r.end_year  : in_r.start_year;
  assign cur_p = cur_y - gdd_pkg::YEAR_W'(1);
  assign quot  = prod_r[gdd_pkg::PROD_W-1:gdd_pkg::RECIP_SH];
  assign cent  = (prod_r == gdd_pkg::PROD_W'(cur_y));

  assign date_ok = (cur_y != '0)
                && (gdd_pkg::YMAX_W'(cur_y) <= gdd_pkg::YMAX_W'(YEAR_MAX))
                && (cur_m >= gdd_pkg::MONTH_W'(1)) && (cur_m <= gdd_pkg::MONTH_W'(12))
                && (cur_d != '0)
                && (cur_d <= gdd_pkg::month_len(cur_m, leap_r));

  assign leap_add = leap_r && (cur_m > gdd_pkg::MONTH_W'(2));
  assign serial   = acc_r + SER_W'(qp_r >> 2) + SER_W'(gdd_pkg::days_before(cur_m))
                  + SER_W'(leap_add) + SER_W'(cur_d);

  assign diff     = (ser_b_r > ser_a_r) ? (ser_b_r - ser_a_r) : '0;
  assign cnt      = diff + SER_W'(in_r.count_end_day);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_YQ: begin
        mul_a = cur_y;
        mul_b = gdd_pkg::RECIP_100;
      end
      ST_YR: begin
        mul_a = MUL_W'(quot);
        mul_b = gdd_pkg::CENTURY;
      end
      ST_PQ: begin
        mul_a = cur_p;
        mul_b = gdd_pkg::RECIP_100;
      end
      ST_PM: begin
        mul_a = cur_p;
        mul_b = gdd_pkg::YEAR_DAYS;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    in_nxt        = in_r;
    qy_nxt        = qy_r;
    qp_nxt        = qp_r;
    leap_nxt      = leap_r;
    acc_nxt       = acc_r;
    ser_a_nxt     = ser_a_r;
    ser_b_nxt     = ser_b_r;
    bad_nxt       = bad_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          sel_nxt   = 1'b0;
          bad_nxt   = 1'b0;
          state_nxt = ST_YQ;
        end
      end
      ST_YQ: begin
        state_nxt = ST_YR;
      end
      ST_YR: begin
        qy_nxt    = quot;
        state_nxt = ST_PQ;
      end
      ST_PQ: begin
        // prod holds (year / 100) * 100
        leap_nxt  = (cent && (qy_r[1:0] == 2'b00)) || (!cent && (cur_y[1:0] == 2'b00));
        state_nxt = ST_PM;
      end
      ST_PM: begin
        qp_nxt    = quot;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt   = SER_W'(prod_r) + SER_W'(cur_p >> 2) - SER_W'(qp_r);
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        bad_nxt = bad_r || !date_ok;
        if (sel_r) begin
          ser_b_nxt = serial;
          state_nxt = ST_OUT;
        end else begin
          ser_a_nxt = serial;
          sel_nxt   = 1'b1;
          state_nxt = ST_YQ;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          if (bad_r) begin
            out_nxt.day_count = '0;
            out_nxt.status    = gdd_pkg::STATUS_BAD;
          end else begin
            out_nxt.day_count = cnt[gdd_pkg::COUNT_W-1:0];
            out_nxt.status    = gdd_pkg::STATUS_OK;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r   <= sel_nxt;
    in_r    <= in_nxt;
    qy_r    <= qy_nxt;
    qp_r    <= qp_nxt;
    leap_r  <= leap_nxt;
    acc_r   <= acc_nxt;
    ser_a_r <= ser_a_nxt;
    ser_b_r <= ser_b_nxt;
    bad_r   <= bad_nxt;
    out_r   <= out_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // error results carry a zero count
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == gdd_pkg::STATUS_BAD) |-> out_data.day_count == '0)
    else $error("error item with nonzero count");

  // an accepted item starts on the start date
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> (state_r == ST_YQ) && !sel_r)
    else $error("item did not start on start date");

  // second date finishing leads to result stage
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) && sel_r |=> state_r == ST_OUT)
    else $error("end date did not lead to result stage");

  // a fresh result only appears on leaving the result stage
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_OUT)
    else $error("result appeared outside result stage");

endmodule
`default_nettype wire
